// ----- rtl/core/mcc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcc_pkg
// Types, character codes and the letter table of the Morse codec.
// ----------------------------------------------------------------------------
package mcc_pkg;

   // request function codes
   localparam logic FUNC_ENCODE = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // ASCII characters in use
   localparam logic [7:0] CHAR_DOT      = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_DASH     = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_SPACE    = 8'h20;  // ' '
   localparam logic [7:0] CHAR_UNKNOWN  = 8'h3F;  // '?'
   localparam logic [7:0] CHAR_LETTER_A = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_LETTER_Z = 8'h5A;  // 'Z'

   localparam int unsigned NUM_LETTERS = 26;
   localparam int unsigned MAX_SYMBOLS = 4;

   localparam logic [2:0] LEN_OVERFLOW = 3'd5;
   localparam logic [2:0] LEN_FULL     = 3'd4;

   typedef struct packed {
      logic       func;
      logic [7:0] char_in;
      logic       end_of_line;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_payload_type;

   // symbol i of a code sits in dash[i], 1 = dash
   typedef struct packed {
      logic [2:0] len;
      logic [3:0] dash;
   } morse_entry_type;

   localparam morse_entry_type MORSE_TABLE [NUM_LETTERS] = '{
      '{3'd2, 4'b0010},  // A
      '{3'd4, 4'b0001},  // B
      '{3'd4, 4'b0101},  // C
      '{3'd3, 4'b0001},  // D
      '{3'd1, 4'b0000},  // E
      '{3'd4, 4'b0100},  // F
      '{3'd3, 4'b0011},  // G
      '{3'd4, 4'b0000},  // H
      '{3'd2, 4'b0000},  // I
      '{3'd4, 4'b1110},  // J
      '{3'd3, 4'b0101},  // K
      '{3'd4, 4'b0010},  // L
      '{3'd2, 4'b0011},  // M
      '{3'd2, 4'b0001},  // N
      '{3'd3, 4'b0111},  // O
      '{3'd4, 4'b0110},  // P
      '{3'd4, 4'b1011},  // Q
      '{3'd3, 4'b0010},  // R
      '{3'd3, 4'b0000},  // S
      '{3'd1, 4'b0001},  // T
      '{3'd3, 4'b0100},  // U
      '{3'd4, 4'b1000},  // V
      '{3'd3, 4'b0110},  // W
      '{3'd4, 4'b1001},  // X
      '{3'd4, 4'b1101},  // Y
      '{3'd4, 4'b0011}   // Z
   };

   function automatic logic is_letter(input logic [7:0] ch);
      return (ch >= CHAR_LETTER_A) && (ch <= CHAR_LETTER_Z);
   endfunction

   function automatic morse_entry_type encode_letter(input logic [7:0] ch);
      logic [7:0] offset;
      offset = ch - CHAR_LETTER_A;
      return MORSE_TABLE[offset[4:0]];
   endfunction

   // parallel compare against all letters; codes are unique
   function automatic logic [7:0] decode_code(input logic [2:0] len,
                                              input logic [3:0] dash);
      logic [7:0] result;
      result = CHAR_UNKNOWN;
      for (int i = 0; i < NUM_LETTERS; i++) begin
         if (MORSE_TABLE[i].len == len && MORSE_TABLE[i].dash == dash) begin
            result = CHAR_LETTER_A + 8'(i);
         end
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/morse_code_codec.sv -----
// ----------------------------------------------------------------------------
// morse_code_codec
// Byte-stream Morse encoder/decoder over the letters A-Z.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  req     | in        | req_valid/req_stall| func, char_in, end_of_line
//  rsp     | out       | rsp_valid/rsp_stall| char_out, last
//
//  Each request is worked in one pass when accepted: the decode register is
//  updated and its burst (0 to 5 characters) is written to a burst register.
//  The burst drains into the output register at one character per cycle while
//  rsp_stall allows; an encoded letter gives 2 to 5 characters, a decode byte
//  that flushes collected symbols 1 and any other request none. The next
//  request is taken in the cycle its predecessor's last character moves to the
//  output register. On accept the burst is loaded into the burst register, from
//  which its first character then moves to the output register.
//  Reset (synchronous) clears the decode register, burst and output valid.
//  rsp_stall holds the output register and, while the burst still holds
//  characters, the request side.
//
module morse_code_codec
   import mcc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // decode register: collected symbols and their count (5 = overflowed)
   logic [3:0] pend_code_ff, pend_code_in;
   logic [2:0] pend_len_ff,  pend_len_in;

   // burst: cnt characters, the first cnt-1 are dots/dashes from dash,
   // the final one is term
   logic [3:0] bst_dash_ff, bst_dash_in;
   logic [7:0] bst_term_ff, bst_term_in;
   logic [2:0] bst_cnt_ff,  bst_cnt_in;
   logic [2:0] bst_pos_ff,  bst_pos_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff,  rsp_data_in;

   logic req_fire;
   logic out_adv;
   logic bst_busy;
   logic bst_final;

   // request working signals
   logic            is_sym;
   logic            do_flush;
   logic [3:0]      sym_code;
   logic [2:0]      sym_len;
   morse_entry_type enc;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign bst_busy  = bst_pos_ff != bst_cnt_ff;
   assign bst_final = bst_pos_ff == (bst_cnt_ff - 3'd1);

   // free once the last character of the burst is moving out
   assign req_stall = bst_busy && !(bst_final && out_adv);
   assign req_fire  = req_valid && !req_stall;

   // --- request pass --------------------------------------------------------
   always_comb begin
      enc      = encode_letter(req_payload.char_in);
      is_sym   = (req_payload.char_in == CHAR_DOT) || (req_payload.char_in == CHAR_DASH);

      // symbol collection, saturating beyond four
      sym_code = pend_code_ff;
      sym_len  = pend_len_ff;
      if (is_sym) begin
         if (pend_len_ff < LEN_FULL) begin
            if (req_payload.char_in == CHAR_DASH) begin
               sym_code = pend_code_ff | (4'b0001 << pend_len_ff[1:0]);
            end
            sym_len = pend_len_ff + 3'd1;
         end else begin
            sym_len = LEN_OVERFLOW;
         end
      end

      do_flush = is_sym ? req_payload.end_of_line
                        : (req_payload.char_in == CHAR_SPACE) || req_payload.end_of_line;

      pend_code_in = pend_code_ff;
      pend_len_in  = pend_len_ff;
      bst_dash_in  = bst_dash_ff;
      bst_term_in  = bst_term_ff;
      bst_cnt_in   = bst_cnt_ff;
      bst_pos_in   = bst_pos_ff;

      // drain one character when the output register can take it
      if (bst_busy && out_adv) begin
         bst_pos_in = bst_pos_ff + 3'd1;
      end

      if (req_fire) begin
         bst_pos_in = 3'd0;
         bst_cnt_in = 3'd0;
         case (req_payload.func)
            FUNC_ENCODE: begin
               if (is_letter(req_payload.char_in)) begin
                  bst_dash_in = enc.dash;
                  bst_term_in = CHAR_SPACE;
                  bst_cnt_in  = enc.len + 3'd1;
               end
            end
            FUNC_DECODE: begin
               pend_code_in = sym_code;
               pend_len_in  = sym_len;
               if (do_flush) begin
                  pend_code_in = 4'd0;
                  pend_len_in  = 3'd0;
                  if (sym_len != 3'd0) begin
                     bst_term_in = (sym_len > LEN_FULL) ? CHAR_UNKNOWN
                                                        : decode_code(sym_len, sym_code);
                     bst_cnt_in  = 3'd1;
                  end
               end
            end
            default: begin
               bst_cnt_in = 3'd0;
            end
         endcase
      end
   end

   // --- output register -----------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_adv) begin
         rsp_valid_in     = bst_busy;
         rsp_data_in.last = bst_final;
         if (bst_final) begin
            rsp_data_in.char_out = bst_term_ff;
         end else begin
            rsp_data_in.char_out = bst_dash_ff[bst_pos_ff[1:0]] ? CHAR_DASH : CHAR_DOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_code_ff <= 4'd0;
         pend_len_ff  <= 3'd0;
         bst_cnt_ff   <= 3'd0;
         bst_pos_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_code_ff <= pend_code_in;
         pend_len_ff  <= pend_len_in;
         bst_cnt_ff   <= bst_cnt_in;
         bst_pos_ff   <= bst_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bst_dash_ff <= bst_dash_in;
      bst_term_ff <= bst_term_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // --- checks --------------------------------------------------------------
   // drain pointer never passes the burst length
   a_pos_in_range : assert property (@(posedge clock) disable iff (reset)
      bst_pos_ff <= bst_cnt_ff)
      else $error("burst pointer beyond burst length");

   // a request is never taken while more than its predecessor's last char remains
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!bst_busy || bst_final))
      else $error("request accepted over an undrained burst");

   // an encoded letter always loads a burst of two to five characters
   a_enc_burst : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.func == FUNC_ENCODE && is_letter(req_payload.char_in))
      |=> (bst_cnt_ff >= 3'd2 && bst_cnt_ff <= 3'd5 && bst_pos_ff == 3'd0))
      else $error("encoded letter gave a bad burst");

   // a flushing decode request leaves the decode register empty
   a_flush_clears : assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.func == FUNC_DECODE && do_flush)
      |=> (pend_len_ff == 3'd0 && pend_code_ff == 4'd0))
      else $error("decode register not cleared by flush");

endmodule
